[src/bda_pkg.sv]
// Shared types, constants and register codes for the button debounce and autorepeat block
package bda_pkg;

	localparam int NUM_BUTTONS   = 5;
	localparam int NUM_CHANNELS  = 9;
	localparam int SAMPLE_BITS   = 12;
	localparam int INTEG_BITS    = 8;
	localparam int COUNT_BITS    = 16;
	localparam logic [INTEG_BITS-1:0] DEBOUNCE_FULL = 8'd100;

	localparam int CH_RIGHT = 5;
	localparam int CH_LEFT  = 6;
	localparam int CH_UP    = 7;
	localparam int CH_DOWN  = 8;

	localparam int IN_DATA_BITS  = 32;
	localparam int OUT_DATA_BITS = 24;
	localparam int ADDR_BITS     = 5;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_STEP_UP        = 3'd0,
		REG_STEP_DOWN      = 3'd1,
		REG_UPPER_PRESS    = 3'd2,
		REG_UPPER_RELEASE  = 3'd3,
		REG_LOWER_PRESS    = 3'd4,
		REG_LOWER_RELEASE  = 3'd5,
		REG_REPEAT_DELAY   = 3'd6,
		REG_REPEAT_INTERVAL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [INTEG_BITS-1:0]  step_up;
		logic [INTEG_BITS-1:0]  step_down;
		logic [SAMPLE_BITS-1:0] upper_press_level;
		logic [SAMPLE_BITS-1:0] upper_release_level;
		logic [SAMPLE_BITS-1:0] lower_press_level;
		logic [SAMPLE_BITS-1:0] lower_release_level;
		logic [COUNT_BITS-1:0]  repeat_delay;
		logic [COUNT_BITS-1:0]  repeat_interval;
	} bda_cfg_t;

	localparam bda_cfg_t CFG_RESET = '{
		step_up:             8'd10,
		step_down:           8'd10,
		upper_press_level:   12'd3595,
		upper_release_level: 12'd3095,
		lower_press_level:   12'd500,
		lower_release_level: 12'd1000,
		repeat_delay:        16'd100,
		repeat_interval:     16'd30
	};

endpackage

[src/bda_debounce.sv]
// Button integrators, joystick hysteresis and the debounced state register
module bda_debounce import bda_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  bda_cfg_t                cfg,
	input  logic [NUM_BUTTONS-1:0]  raw_buttons,
	input  logic [SAMPLE_BITS-1:0]  joy_x,
	input  logic [SAMPLE_BITS-1:0]  joy_y,
	output logic [NUM_CHANNELS-1:0] bits_old,
	output logic [NUM_CHANNELS-1:0] bits_new
);

	logic [INTEG_BITS-1:0]   integ_q [NUM_BUTTONS];
	logic [INTEG_BITS-1:0]   integ_d [NUM_BUTTONS];
	logic [NUM_CHANNELS-1:0] bits_q;

	always_comb begin
		logic [INTEG_BITS:0] sum;
		bits_new = bits_q;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			sum = {1'b0, integ_q[i]} + {1'b0, cfg.step_up};
			if (raw_buttons[i]) begin
				if (sum >= {1'b0, DEBOUNCE_FULL}) begin
					integ_d[i]  = DEBOUNCE_FULL;
					bits_new[i] = 1'b1;
				end else begin
					integ_d[i] = sum[INTEG_BITS-1:0];
				end
			end else begin
				if (integ_q[i] <= cfg.step_down) begin
					integ_d[i]  = '0;
					bits_new[i] = 1'b0;
				end else begin
					integ_d[i] = integ_q[i] - cfg.step_down;
				end
			end
		end

		if (joy_x > cfg.upper_press_level)   bits_new[CH_RIGHT] = 1'b1;
		if (joy_x < cfg.upper_release_level) bits_new[CH_RIGHT] = 1'b0;
		if (joy_x < cfg.lower_press_level)   bits_new[CH_LEFT]  = 1'b1;
		if (joy_x > cfg.lower_release_level) bits_new[CH_LEFT]  = 1'b0;
		if (joy_y > cfg.upper_press_level)   bits_new[CH_UP]    = 1'b1;
		if (joy_y < cfg.upper_release_level) bits_new[CH_UP]    = 1'b0;
		if (joy_y < cfg.lower_press_level)   bits_new[CH_DOWN]  = 1'b1;
		if (joy_y > cfg.lower_release_level) bits_new[CH_DOWN]  = 1'b0;
	end

	assign bits_old = bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) integ_q[i] <= '0;
		end else if (adv) begin
			bits_q <= bits_new;
			for (int i = 0; i < NUM_BUTTONS; i++) integ_q[i] <= integ_d[i];
		end
	end

endmodule

[src/bda_repeat.sv]
// Per-channel hold and phase counters that fire autorepeat presses
module bda_repeat import bda_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  bda_cfg_t                cfg,
	input  logic [NUM_CHANNELS-1:0] held,
	output logic [NUM_CHANNELS-1:0] fire
);

	logic [COUNT_BITS-1:0] hold_q  [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] phase_q [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] hold_d  [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] phase_d [NUM_CHANNELS];

	always_comb begin
		logic [COUNT_BITS-1:0] inc;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			hold_d[c]  = hold_q[c];
			phase_d[c] = phase_q[c];
			fire[c]    = 1'b0;
			inc        = '0;
			if (!held[c]) begin
				hold_d[c]  = '0;
				phase_d[c] = '0;
			end else if (hold_q[c] < cfg.repeat_delay) begin
				hold_d[c] = hold_q[c] + 1'b1;
				if (hold_d[c] == cfg.repeat_delay) begin
					phase_d[c] = '0;
					fire[c]    = 1'b1;
				end
			end else begin
				inc = phase_q[c] + 1'b1;
				if (inc >= cfg.repeat_interval) begin
					phase_d[c] = '0;
					fire[c]    = 1'b1;
				end else begin
					phase_d[c] = inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				hold_q[c]  <= '0;
				phase_q[c] <= '0;
			end
		end else if (adv) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				hold_q[c]  <= hold_d[c];
				phase_q[c] <= phase_d[c];
			end
		end
	end

endmodule

[src/bda_regs.sv]
// APB configuration register file
module bda_regs import bda_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output bda_cfg_t                 cfg
);

	bda_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			case (idx)
				REG_STEP_UP:         cfg_q.step_up             <= pwdata[INTEG_BITS-1:0];
				REG_STEP_DOWN:       cfg_q.step_down           <= pwdata[INTEG_BITS-1:0];
				REG_UPPER_PRESS:     cfg_q.upper_press_level   <= pwdata[SAMPLE_BITS-1:0];
				REG_UPPER_RELEASE:   cfg_q.upper_release_level <= pwdata[SAMPLE_BITS-1:0];
				REG_LOWER_PRESS:     cfg_q.lower_press_level   <= pwdata[SAMPLE_BITS-1:0];
				REG_LOWER_RELEASE:   cfg_q.lower_release_level <= pwdata[SAMPLE_BITS-1:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay        <= pwdata[COUNT_BITS-1:0];
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval     <= pwdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STEP_UP:         prdata = APB_DATA_BITS'(cfg_q.step_up);
			REG_STEP_DOWN:       prdata = APB_DATA_BITS'(cfg_q.step_down);
			REG_UPPER_PRESS:     prdata = APB_DATA_BITS'(cfg_q.upper_press_level);
			REG_UPPER_RELEASE:   prdata = APB_DATA_BITS'(cfg_q.upper_release_level);
			REG_LOWER_PRESS:     prdata = APB_DATA_BITS'(cfg_q.lower_press_level);
			REG_LOWER_RELEASE:   prdata = APB_DATA_BITS'(cfg_q.lower_release_level);
			REG_REPEAT_DELAY:    prdata = APB_DATA_BITS'(cfg_q.repeat_delay);
			REG_REPEAT_INTERVAL: prdata = APB_DATA_BITS'(cfg_q.repeat_interval);
			default:             prdata = '0;
		endcase
	end

endmodule

[src/button_debounce_autorepeat.sv]
// Top level: input register, debounce and autorepeat logic, output register
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: raw_buttons, joy_x, joy_y
//  m_axis    out        m_axis_tvalid/tready      tdata: debounced, presses
//  apb       in         psel/penable/pready       paddr, pwdata, prdata
//
// One word per cycle while the output is not stalled; each word passes through the input
// register, then the result register, before it leaves. The scan state updates when a
// word moves from the input register into the result register.
// Reset clears all integrators, counters and debounced bits and loads the
// register defaults. A stalled output holds one word in the result register
// and one in the input register before s_axis_tready drops.
module button_debounce_autorepeat import bda_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// [4:0] raw_buttons, [16:5] joy_x, [28:17] joy_y, [31:29] zero
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [8:0] debounced, [17:9] presses, [23:18] zero
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	bda_cfg_t cfg;

	logic                    valid_s1;
	logic [NUM_BUTTONS-1:0]  raw_s1;
	logic [SAMPLE_BITS-1:0]  joy_x_s1;
	logic [SAMPLE_BITS-1:0]  joy_y_s1;
	logic                    valid_s2;
	logic [NUM_CHANNELS-1:0] debounced_s2;
	logic [NUM_CHANNELS-1:0] presses_s2;

	logic                    adv;
	logic                    s_acc;
	logic [NUM_CHANNELS-1:0] bits_old;
	logic [NUM_CHANNELS-1:0] bits_new;
	logic [NUM_CHANNELS-1:0] fire;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	bda_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			raw_s1   <= s_axis_tdata[NUM_BUTTONS-1:0];
			joy_x_s1 <= s_axis_tdata[NUM_BUTTONS +: SAMPLE_BITS];
			joy_y_s1 <= s_axis_tdata[NUM_BUTTONS+SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	bda_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg),
		.raw_buttons (raw_s1),
		.joy_x       (joy_x_s1),
		.joy_y       (joy_y_s1),
		.bits_old    (bits_old),
		.bits_new    (bits_new)
	);

	bda_repeat u_repeat (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.held   (bits_new),
		.fire   (fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			debounced_s2 <= bits_new;
			presses_s2   <= (~bits_old & bits_new) | fire;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_DATA_BITS - 2*NUM_CHANNELS)'(0), presses_s2, debounced_s2};

`ifndef SYNTHESIS
	a_press_needs_set: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((presses_s2 & ~debounced_s2) == '0))
		else $error("press reported on a channel that is not set");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	a_adv_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced word did not reach the output register");
`endif

endmodule

[sim/bda_checker.sv]
// Checker for the button debounce and autorepeat block: tracks scan ticks and compares results
module bda_checker import bda_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	// [4:0] raw_buttons, [16:5] joy_x, [28:17] joy_y, [31:29] zero
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [8:0] debounced, [17:9] presses, [23:18] zero
	input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output int                       errors,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0] presses;
		logic [NUM_CHANNELS-1:0] debounced;
	} scan_result_t;

	bda_cfg_t                cfg;
	logic [INTEG_BITS-1:0]   integ [NUM_BUTTONS];
	logic [NUM_CHANNELS-1:0] deb_state;
	logic [COUNT_BITS-1:0]   hold_cnt [NUM_CHANNELS];
	logic [COUNT_BITS-1:0]   rep_phase [NUM_CHANNELS];
	scan_result_t            expected_scans [$];

	function automatic logic [NUM_CHANNELS-1:0] apply_axis(logic [NUM_CHANNELS-1:0] bits,
			logic [SAMPLE_BITS-1:0] s, int hi_ch, int lo_ch);
		if (s > cfg.upper_press_level) bits[hi_ch] = 1'b1;
		if (s < cfg.upper_release_level) bits[hi_ch] = 1'b0;
		if (s < cfg.lower_press_level) bits[lo_ch] = 1'b1;
		if (s > cfg.lower_release_level) bits[lo_ch] = 1'b0;
		return bits;
	endfunction

	task automatic scan_tick(input logic [NUM_BUTTONS-1:0] raw, input logic [SAMPLE_BITS-1:0] jx,
			input logic [SAMPLE_BITS-1:0] jy, output scan_result_t res);
		int sum;
		logic [NUM_CHANNELS-1:0] bits;
		bits = deb_state;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (raw[i]) begin
				sum = int'(integ[i]) + int'(cfg.step_up);
				if (sum >= int'(DEBOUNCE_FULL)) begin
					sum = int'(DEBOUNCE_FULL);
					bits[i] = 1'b1;
				end
			end else begin
				sum = int'(integ[i]) - int'(cfg.step_down);
				if (sum <= 0) begin
					sum = 0;
					bits[i] = 1'b0;
				end
			end
			integ[i] = sum[INTEG_BITS-1:0];
		end
		bits = apply_axis(bits, jx, CH_RIGHT, CH_LEFT);
		bits = apply_axis(bits, jy, CH_UP, CH_DOWN);
		res.presses = ~deb_state & bits;
		res.debounced = bits;
		deb_state = bits;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			if (!bits[ch]) begin
				hold_cnt[ch] = '0;
				rep_phase[ch] = '0;
			end else if (hold_cnt[ch] < cfg.repeat_delay) begin
				hold_cnt[ch] = hold_cnt[ch] + 1'b1;
				if (hold_cnt[ch] == cfg.repeat_delay) begin
					rep_phase[ch] = '0;
					res.presses[ch] = 1'b1;
				end
			end else begin
				rep_phase[ch] = rep_phase[ch] + 1'b1;
				if (rep_phase[ch] >= cfg.repeat_interval) begin
					rep_phase[ch] = '0;
					res.presses[ch] = 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t got;
		scan_result_t want;
		if (!arst_n) begin
			cfg = CFG_RESET;
			deb_state = '0;
			for (int i = 0; i < NUM_BUTTONS; i++) integ[i] = '0;
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				hold_cnt[ch] = '0;
				rep_phase[ch] = '0;
			end
			expected_scans.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.debounced = m_axis_tdata[NUM_CHANNELS-1:0];
				got.presses = m_axis_tdata[2*NUM_CHANNELS-1:NUM_CHANNELS];
				if (expected_scans.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected word debounced %03h presses %03h",
							$realtime, got.debounced, got.presses);
					errors++;
				end else begin
					want = expected_scans.pop_front();
					if (got.debounced !== want.debounced || got.presses !== want.presses) begin
						if (errors < 10)
							$display("%0t: mismatch debounced exp %03h got %03h, presses exp %03h got %03h",
								$realtime, want.debounced, got.debounced, want.presses, got.presses);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scan_tick(s_axis_tdata[NUM_BUTTONS-1:0],
					s_axis_tdata[NUM_BUTTONS+SAMPLE_BITS-1:NUM_BUTTONS],
					s_axis_tdata[NUM_BUTTONS+2*SAMPLE_BITS-1:NUM_BUTTONS+SAMPLE_BITS], want);
				expected_scans.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_STEP_UP:         cfg.step_up = pwdata[INTEG_BITS-1:0];
					REG_STEP_DOWN:       cfg.step_down = pwdata[INTEG_BITS-1:0];
					REG_UPPER_PRESS:     cfg.upper_press_level = pwdata[SAMPLE_BITS-1:0];
					REG_UPPER_RELEASE:   cfg.upper_release_level = pwdata[SAMPLE_BITS-1:0];
					REG_LOWER_PRESS:     cfg.lower_press_level = pwdata[SAMPLE_BITS-1:0];
					REG_LOWER_RELEASE:   cfg.lower_release_level = pwdata[SAMPLE_BITS-1:0];
					REG_REPEAT_DELAY:    cfg.repeat_delay = pwdata[COUNT_BITS-1:0];
					REG_REPEAT_INTERVAL: cfg.repeat_interval = pwdata[COUNT_BITS-1:0];
					default: ;
				endcase
			end
			pending = expected_scans.size();
		end
	end

endmodule

[sim/button_debounce_autorepeat_test.sv]
// Testbench top for the button debounce and autorepeat block: stimulus, watchdog and verdict
module button_debounce_autorepeat_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bda_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 80;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_BITS-1:0]     paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int                       errors;
	int                       pending;
	int                       idle_cycles = 0;
	int                       stall_left = 0;
	logic                     idling_on;
	logic [NUM_BUTTONS-1:0]   held_buttons;
	logic [SAMPLE_BITS-1:0]   stick_x;
	logic [SAMPLE_BITS-1:0]   stick_y;

	button_debounce_autorepeat dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	bda_checker press_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.errors       (errors),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[button_debounce_autorepeat] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_config(input bda_cfg_t c);
		apb_write(REG_STEP_UP, APB_DATA_BITS'(c.step_up));
		apb_write(REG_STEP_DOWN, APB_DATA_BITS'(c.step_down));
		apb_write(REG_UPPER_PRESS, APB_DATA_BITS'(c.upper_press_level));
		apb_write(REG_UPPER_RELEASE, APB_DATA_BITS'(c.upper_release_level));
		apb_write(REG_LOWER_PRESS, APB_DATA_BITS'(c.lower_press_level));
		apb_write(REG_LOWER_RELEASE, APB_DATA_BITS'(c.lower_release_level));
		apb_write(REG_REPEAT_DELAY, APB_DATA_BITS'(c.repeat_delay));
		apb_write(REG_REPEAT_INTERVAL, APB_DATA_BITS'(c.repeat_interval));
	endtask

	task automatic send_scan(input logic [NUM_BUTTONS-1:0] raw, input logic [SAMPLE_BITS-1:0] jx,
			input logic [SAMPLE_BITS-1:0] jy);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, jy, jx, raw};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	// hold off the sender until every word has come back
	task automatic wait_results;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int pick_value(int hi, int typical);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return hi;
			2: return 1;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	function automatic bda_cfg_t random_config();
		bda_cfg_t c;
		logic [SAMPLE_BITS-1:0] t;
		c.step_up = INTEG_BITS'(pick_value(255, 255));
		c.step_down = INTEG_BITS'(pick_value(255, 255));
		c.upper_press_level = SAMPLE_BITS'(pick_value(4095, 4095));
		c.upper_release_level = SAMPLE_BITS'(pick_value(4095, 4095));
		c.lower_press_level = SAMPLE_BITS'(pick_value(4095, 4095));
		c.lower_release_level = SAMPLE_BITS'(pick_value(4095, 4095));
		if ($urandom_range(0, 1) == 0) begin
			if (c.upper_release_level > c.upper_press_level) begin
				t = c.upper_release_level;
				c.upper_release_level = c.upper_press_level;
				c.upper_press_level = t;
			end
			if (c.lower_press_level > c.lower_release_level) begin
				t = c.lower_press_level;
				c.lower_press_level = c.lower_release_level;
				c.lower_release_level = t;
			end
		end
		c.repeat_delay = COUNT_BITS'(pick_value(65535, 20));
		c.repeat_interval = COUNT_BITS'(pick_value(65535, 12));
		return c;
	endfunction

	// held buttons and stick positions with bounce and jitter on top
	task automatic random_scans(input int count);
		logic [NUM_BUTTONS-1:0] raw;
		logic [SAMPLE_BITS-1:0] jx;
		logic [SAMPLE_BITS-1:0] jy;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 7) == 0) held_buttons = NUM_BUTTONS'($urandom_range(0, 31));
			if ($urandom_range(0, 9) == 0) stick_x = SAMPLE_BITS'(pick_value(4095, 4095));
			if ($urandom_range(0, 9) == 0) stick_y = SAMPLE_BITS'(pick_value(4095, 4095));
			raw = held_buttons;
			if ($urandom_range(0, 5) == 0) raw ^= NUM_BUTTONS'($urandom_range(1, 31));
			jx = stick_x;
			jy = stick_y;
			if ($urandom_range(0, 3) == 0) jx = stick_x + SAMPLE_BITS'($urandom_range(0, 64)) - 12'd32;
			if ($urandom_range(0, 3) == 0) jy = stick_y + SAMPLE_BITS'($urandom_range(0, 64)) - 12'd32;
			if ($urandom_range(0, 99) == 0) wait_results();
			send_scan(raw, jx, jy);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idling_on = 1'b1;
		held_buttons = '0;
		stick_x = 12'd2048;
		stick_y = 12'd2048;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(negedge clk);

		// threshold edges under the reset settings
		send_scan(5'd0, 12'd2048, 12'd2048);
		send_scan(5'd31, 12'd3596, 12'd499);
		send_scan(5'd31, 12'd3595, 12'd500);
		send_scan(5'd31, 12'd3095, 12'd1000);
		send_scan(5'd31, 12'd3094, 12'd1001);
		send_scan(5'd21, 12'd4095, 12'd0);
		send_scan(5'd10, 12'd0, 12'd4095);

		// full steps, overlapping thresholds, zero delay and interval
		wait_results();
		load_config('{step_up: 8'd255, step_down: 8'd255,
			upper_press_level: 12'd1000, upper_release_level: 12'd3000,
			lower_press_level: 12'd3000, lower_release_level: 12'd1000,
			repeat_delay: 16'd0, repeat_interval: 16'd0});
		send_scan(5'd31, 12'd2000, 12'd2000);
		send_scan(5'd31, 12'd4095, 12'd0);
		send_scan(5'd31, 12'd4095, 12'd0);
		send_scan(5'd31, 12'd0, 12'd4095);
		send_scan(5'd0, 12'd2000, 12'd2000);
		send_scan(5'd5, 12'd2000, 12'd2000);

		// zero steps leave the integrators in place
		wait_results();
		load_config('{step_up: 8'd0, step_down: 8'd0,
			upper_press_level: 12'd3595, upper_release_level: 12'd3095,
			lower_press_level: 12'd500, lower_release_level: 12'd1000,
			repeat_delay: 16'd2, repeat_interval: 16'd3});
		send_scan(5'd31, 12'd2048, 12'd2048);
		send_scan(5'd0, 12'd2048, 12'd2048);
		send_scan(5'd10, 12'd2048, 12'd2048);
		send_scan(5'd31, 12'd2048, 12'd2048);
		send_scan(5'd0, 12'd2048, 12'd2048);

		// longest delay, then shorten it while held
		wait_results();
		load_config('{step_up: 8'd255, step_down: 8'd1,
			upper_press_level: 12'd3595, upper_release_level: 12'd3095,
			lower_press_level: 12'd500, lower_release_level: 12'd1000,
			repeat_delay: 16'd65535, repeat_interval: 16'd65535});
		repeat (4) send_scan(5'd31, 12'd4095, 12'd4095);
		wait_results();
		load_config('{step_up: 8'd255, step_down: 8'd1,
			upper_press_level: 12'd3595, upper_release_level: 12'd3095,
			lower_press_level: 12'd500, lower_release_level: 12'd1000,
			repeat_delay: 16'd1, repeat_interval: 16'd1});
		repeat (3) send_scan(5'd31, 12'd4095, 12'd4095);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_results();
			load_config(random_config());
			if (p == RANDOM_PHASES - 1) idling_on = 1'b0;
			random_scans(ITEMS_PER_PHASE + $urandom_range(0, 10));
		end

		wait_results();
		if (errors == 0 && pending == 0)
			$display("[button_debounce_autorepeat] OK");
		else
			$display("[button_debounce_autorepeat] ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/bda_pkg.sv
src/bda_debounce.sv
src/bda_repeat.sv
src/bda_regs.sv
src/button_debounce_autorepeat.sv
sim/bda_checker.sv
sim/button_debounce_autorepeat_test.sv
